/* sv/kmc_pkg.sv */
// Package for the 2-D k-means clustering block: default sizes, field widths,
// item kinds and register indexes. Depends on nothing.
`timescale 1ns / 1ps
package kmc_pkg;

  localparam int POINT_DEPTH_DEF    = 4096;
  localparam int CENTROID_DEPTH_DEF = 32;
  localparam int COORD_WIDTH_DEF    = 16;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 12;
  localparam int ITER_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NCLU_W   = 6;
  localparam int NPTS_W   = 13;

  localparam logic [KIND_W-1:0] KIND_LOAD_POINT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_CENTROID = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RUN           = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_LABEL    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_CENTROID = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

  localparam logic [NCLU_W-1:0] NUM_CLUSTERS_RST   = 6'd8;
  localparam logic [NPTS_W-1:0] NUM_POINTS_RST     = 13'd4096;
  localparam logic [ITER_W-1:0] MAX_ITERATIONS_RST = 16'd1000;

endpackage

/* sv/kmc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module kmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/kmc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the centroid update of the clustering block.
`timescale 1ns / 1ps
module kmc_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
        rem_r <= '0;
        quo_r <= num;
        den_r <= den;
      end else if (run_r) begin
        rem_r <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* sv/kmeans_2d_clustering.sv */
// Top level of the 2-D Lloyd k-means clustering block: sequencer, shared
// squaring multiplier and memories. Depends on kmc_pkg, kmc_ram and kmc_div.
//
//   channel   ports                                     handshake
//   input     in_kind in_index in_coord_x in_coord_y    start, busy
//   result    out_label out_x out_y out_iterations      out_valid strobe
//             out_converged
//   config    cfg_index cfg_data                        cfg_valid, cfg_ready
//
// After reset a clearing pass marks every label unassigned; busy is high
// meanwhile. Load items are answered straight from S_IDLE, read items by way
// of S_RDATA, for the registered read of the memories. The length of a run
// pass is set by the one squaring multiplier and the bit-serial divider.
// Each result word is shown for one cycle on out_valid; there is no stall.
`timescale 1ns / 1ps
module kmeans_2d_clustering #(
  parameter int POINT_DEPTH    = kmc_pkg::POINT_DEPTH_DEF,
  parameter int CENTROID_DEPTH = kmc_pkg::CENTROID_DEPTH_DEF,
  parameter int COORD_WIDTH    = kmc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [kmc_pkg::KIND_W-1:0]          in_kind,
  input  logic [kmc_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [COORD_WIDTH-1:0]       in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]       in_coord_y,
  output logic                                out_valid,
  output logic [$clog2(CENTROID_DEPTH)-1:0]   out_label,
  output logic signed [COORD_WIDTH-1:0]       out_x,
  output logic signed [COORD_WIDTH-1:0]       out_y,
  output logic [kmc_pkg::ITER_W-1:0]          out_iterations,
  output logic                                out_converged,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int PAW  = $clog2(POINT_DEPTH);
  localparam int CAW  = $clog2(CENTROID_DEPTH);
  localparam int LW   = CAW + 1;
  localparam int SUMW = CW + PAW + 1;
  localparam int CNTW = PAW + 1;
  localparam int SRW  = 2 * SUMW + CNTW;
  localparam int SQW  = 2 * (CW + 1);
  localparam int DW   = SQW + 1;
  localparam int ITW  = kmc_pkg::ITER_W;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RDATA, S_PCLR, S_CWAIT, S_SQX, S_SQY, S_CMP,
    S_ACC, S_ACCWR, S_UWAIT, S_UCHK, S_DIVX, S_DIVY, S_END
  } state_t;

  state_t state_r;

  logic [kmc_pkg::NCLU_W-1:0] num_clusters_r;
  logic [kmc_pkg::NPTS_W-1:0] num_points_r;
  logic [ITW-1:0]             max_iter_r;
  logic [CAW:0]               k_r;
  logic [PAW:0]               n_r;
  logic [ITW-1:0]             lim_r;
  logic [PAW:0]               p_r;
  logic [CAW:0]               c_r;
  logic [PAW:0]               clr_r;
  logic [CAW-1:0]             best_c_r;
  logic [DW-1:0]              best_d_r;
  logic [SQW-1:0]             sq_r;
  logic [SQW-1:0]             dist_r;
  logic signed [CW:0]         dy_r;
  logic [ITW-1:0]             iter_r;
  logic                       changed_r;
  logic [CW-1:0]              qx_r;
  logic [kmc_pkg::KIND_W-1:0] kind_r;
  logic                       hit_r;

  logic                       out_valid_r;
  logic [CAW-1:0]             out_label_r;
  logic [CW-1:0]              out_x_r;
  logic [CW-1:0]              out_y_r;
  logic [ITW-1:0]             out_iter_r;
  logic                       out_conv_r;

  logic [31:0]   idx32;
  logic          pt_hit;
  logic          ct_hit;
  logic          accept;

  logic          pt_we;
  logic [PAW-1:0] pt_waddr, pt_raddr;
  logic [2*CW-1:0] pt_q;
  logic          lb_we;
  logic [PAW-1:0] lb_waddr, lb_raddr;
  logic [LW-1:0] lb_wdata, lb_q;
  logic          ct_we;
  logic [CAW-1:0] ct_waddr, ct_raddr;
  logic [2*CW-1:0] ct_wdata, ct_q;
  logic          sm_we;
  logic [CAW-1:0] sm_waddr, sm_raddr;
  logic [SRW-1:0] sm_wdata, sm_q;

  logic signed [CW-1:0]   px, py, cx, cy;
  logic signed [CW:0]     dx, dy, mul_a;
  logic signed [SQW-1:0]  prod;
  logic [DW-1:0]          d_now;
  logic signed [SUMW-1:0] sx, sy;
  logic [CNTW-1:0]        cnt;
  logic [LW-1:0]          new_label;

  logic            div_start, div_done;
  logic [SUMW-1:0] div_num, div_quo, abs_x, abs_y;
  logic [CW-1:0]   q_signed;
  logic [ITW:0]    iter_next;

  assign idx32  = 32'(in_index);
  assign pt_hit = idx32 < POINT_DEPTH;
  assign ct_hit = idx32 < CENTROID_DEPTH;
  assign accept = start && (state_r == S_IDLE);
  assign busy   = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  assign px = pt_q[2*CW-1:CW];
  assign py = pt_q[CW-1:0];
  assign cx = ct_q[2*CW-1:CW];
  assign cy = ct_q[CW-1:0];
  assign dx = {px[CW-1], px} - {cx[CW-1], cx};
  assign dy = {py[CW-1], py} - {cy[CW-1], cy};
  assign mul_a = (state_r == S_SQX) ? dx : dy_r;
  assign prod  = mul_a * mul_a;
  assign d_now = DW'(dist_r) + DW'(sq_r);

  assign sx  = sm_q[SRW-1 -: SUMW];
  assign sy  = sm_q[SRW-1-SUMW -: SUMW];
  assign cnt = sm_q[CNTW-1:0];
  assign new_label = {1'b1, best_c_r};

  assign abs_x   = sx[SUMW-1] ? SUMW'(-sx) : SUMW'(sx);
  assign abs_y   = sy[SUMW-1] ? SUMW'(-sy) : SUMW'(sy);
  assign div_num = (state_r == S_UCHK) ? abs_x : abs_y;
  assign div_start = ((state_r == S_UCHK) && (cnt != '0)) ||
                     ((state_r == S_DIVX) && div_done);
  assign q_signed = (state_r == S_DIVX) ?
                    (sx[SUMW-1] ? CW'(-div_quo) : CW'(div_quo)) :
                    (sy[SUMW-1] ? CW'(-div_quo) : CW'(div_quo));
  assign iter_next = {1'b0, iter_r} + 1'b1;

  always_comb begin
    pt_we    = accept && (in_kind == kmc_pkg::KIND_LOAD_POINT) && pt_hit;
    pt_waddr = idx32[PAW-1:0];
    pt_raddr = (state_r == S_IDLE) ? idx32[PAW-1:0] : p_r[PAW-1:0];

    lb_we    = 1'b0;
    lb_waddr = idx32[PAW-1:0];
    lb_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        lb_we    = 1'b1;
        lb_waddr = clr_r[PAW-1:0];
      end
      S_ACCWR: begin
        lb_we    = 1'b1;
        lb_waddr = p_r[PAW-1:0];
        lb_wdata = new_label;
      end
      default: begin
        lb_we = pt_we;
      end
    endcase
    lb_raddr = pt_raddr;

    ct_we    = 1'b0;
    ct_waddr = idx32[CAW-1:0];
    ct_wdata = {in_coord_x, in_coord_y};
    if (state_r == S_DIVY) begin
      ct_we    = div_done;
      ct_waddr = c_r[CAW-1:0];
      ct_wdata = {qx_r, q_signed};
    end else if (accept && (in_kind == kmc_pkg::KIND_LOAD_CENTROID) && ct_hit) begin
      ct_we = 1'b1;
    end
    ct_raddr = (state_r == S_IDLE) ? idx32[CAW-1:0] : c_r[CAW-1:0];

    sm_we    = 1'b0;
    sm_waddr = c_r[CAW-1:0];
    sm_wdata = '0;
    if (state_r == S_PCLR) begin
      sm_we = 1'b1;
    end else if (state_r == S_ACCWR) begin
      sm_we    = 1'b1;
      sm_waddr = best_c_r;
      sm_wdata = {sx + {{(SUMW-CW){px[CW-1]}}, px},
                  sy + {{(SUMW-CW){py[CW-1]}}, py},
                  cnt + 1'b1};
    end
    sm_raddr = ((state_r == S_ACC) || (state_r == S_ACCWR)) ? best_c_r : c_r[CAW-1:0];
  end

  kmc_ram #(.WIDTH(2 * CW), .DEPTH(POINT_DEPTH)) u_points (
    .clk(clk), .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data({in_coord_x, in_coord_y}),
    .rd_addr(pt_raddr), .rd_data(pt_q)
  );

  kmc_ram #(.WIDTH(LW), .DEPTH(POINT_DEPTH)) u_labels (
    .clk(clk), .wr_en(lb_we), .wr_addr(lb_waddr), .wr_data(lb_wdata),
    .rd_addr(lb_raddr), .rd_data(lb_q)
  );

  kmc_ram #(.WIDTH(2 * CW), .DEPTH(CENTROID_DEPTH)) u_centroids (
    .clk(clk), .wr_en(ct_we), .wr_addr(ct_waddr), .wr_data(ct_wdata),
    .rd_addr(ct_raddr), .rd_data(ct_q)
  );

  kmc_ram #(.WIDTH(SRW), .DEPTH(CENTROID_DEPTH)) u_sums (
    .clk(clk), .wr_en(sm_we), .wr_addr(sm_waddr), .wr_data(sm_wdata),
    .rd_addr(sm_raddr), .rd_data(sm_q)
  );

  kmc_div #(.NUM_W(SUMW), .DEN_W(CNTW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(cnt),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_r          <= '0;
      num_clusters_r <= kmc_pkg::NUM_CLUSTERS_RST;
      num_points_r   <= kmc_pkg::NUM_POINTS_RST;
      max_iter_r     <= kmc_pkg::MAX_ITERATIONS_RST;
      out_valid_r    <= 1'b0;
      out_label_r    <= '0;
      out_x_r        <= '0;
      out_y_r        <= '0;
      out_iter_r     <= '0;
      out_conv_r     <= 1'b0;
      changed_r      <= 1'b0;
      iter_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          kmc_pkg::CFG_NUM_CLUSTERS:   num_clusters_r <= cfg_data[kmc_pkg::NCLU_W-1:0];
          kmc_pkg::CFG_NUM_POINTS:     num_points_r   <= cfg_data[kmc_pkg::NPTS_W-1:0];
          kmc_pkg::CFG_MAX_ITERATIONS: max_iter_r     <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (PAW+1)'(POINT_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            out_label_r <= '0;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_iter_r  <= '0;
            out_conv_r  <= 1'b0;
            kind_r      <= in_kind;
            hit_r       <= (in_kind == kmc_pkg::KIND_READ_LABEL) ? pt_hit : ct_hit;
            case (in_kind)
              kmc_pkg::KIND_RUN: begin
                if (num_clusters_r == '0) begin
                  k_r <= (CAW+1)'(1);
                end else if (32'(num_clusters_r) > CENTROID_DEPTH) begin
                  k_r <= (CAW+1)'(CENTROID_DEPTH);
                end else begin
                  k_r <= (CAW+1)'(num_clusters_r);
                end
                if (32'(num_points_r) > POINT_DEPTH) begin
                  n_r <= (PAW+1)'(POINT_DEPTH);
                end else begin
                  n_r <= (PAW+1)'(num_points_r);
                end
                lim_r     <= (max_iter_r == '0) ? ITW'(1) : max_iter_r;
                iter_r    <= '0;
                changed_r <= 1'b0;
                c_r       <= '0;
                state_r   <= S_PCLR;
              end
              kmc_pkg::KIND_READ_LABEL, kmc_pkg::KIND_READ_CENTROID: begin
                state_r <= S_RDATA;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_RDATA: begin
          out_valid_r <= 1'b1;
          if (hit_r && (kind_r == kmc_pkg::KIND_READ_LABEL) && lb_q[LW-1]) begin
            out_label_r <= lb_q[CAW-1:0];
          end
          if (hit_r && (kind_r == kmc_pkg::KIND_READ_CENTROID)) begin
            out_x_r <= cx;
            out_y_r <= cy;
          end
          state_r <= S_IDLE;
        end
        S_PCLR: begin
          if (c_r == k_r - 1'b1) begin
            c_r     <= '0;
            p_r     <= '0;
            state_r <= (n_r == '0) ? S_UWAIT : S_CWAIT;
          end else begin
            c_r <= c_r + 1'b1;
          end
        end
        S_CWAIT: begin
          state_r <= S_SQX;
        end
        S_SQX: begin
          sq_r    <= SQW'(prod);
          dy_r    <= dy;
          state_r <= S_SQY;
        end
        S_SQY: begin
          sq_r    <= SQW'(prod);
          dist_r  <= sq_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if ((c_r == '0) || (d_now <= best_d_r)) begin
            best_d_r <= d_now;
            best_c_r <= c_r[CAW-1:0];
          end
          if (c_r == k_r - 1'b1) begin
            state_r <= S_ACC;
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= S_CWAIT;
          end
        end
        S_ACC: begin
          state_r <= S_ACCWR;
        end
        S_ACCWR: begin
          if (lb_q != new_label) begin
            changed_r <= 1'b1;
          end
          c_r <= '0;
          if (p_r == n_r - 1'b1) begin
            state_r <= S_UWAIT;
          end else begin
            p_r     <= p_r + 1'b1;
            state_r <= S_CWAIT;
          end
        end
        S_UWAIT: begin
          state_r <= S_UCHK;
        end
        S_UCHK: begin
          if (cnt != '0) begin
            state_r <= S_DIVX;
          end else if (c_r == k_r - 1'b1) begin
            state_r <= S_END;
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= S_UWAIT;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            qx_r    <= q_signed;
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            if (c_r == k_r - 1'b1) begin
              state_r <= S_END;
            end else begin
              c_r     <= c_r + 1'b1;
              state_r <= S_UWAIT;
            end
          end
        end
        S_END: begin
          iter_r <= iter_next[ITW-1:0];
          if (changed_r && (iter_next < {1'b0, lim_r})) begin
            changed_r <= 1'b0;
            c_r       <= '0;
            state_r   <= S_PCLR;
          end else begin
            out_valid_r <= 1'b1;
            out_iter_r  <= iter_next[ITW-1:0];
            out_conv_r  <= !changed_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_label      = out_label_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_iterations = out_iter_r;
  assign out_converged  = out_conv_r;

endmodule

/* sv/kmc_checker.sv */
// Port-level checker for the clustering block, bound to the top level.
// Depends on kmc_pkg and kmeans_2d_clustering.
`timescale 1ns / 1ps
module kmc_port_checker #(
  parameter int LABEL_W = 5,
  parameter int COORD_W = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [kmc_pkg::KIND_W-1:0]    in_kind,
  input logic                          out_valid,
  input logic [LABEL_W-1:0]            out_label,
  input logic [COORD_W-1:0]            out_x,
  input logic [COORD_W-1:0]            out_y,
  input logic [kmc_pkg::ITER_W-1:0]    out_iterations,
  input logic                          out_converged
);

  a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == kmc_pkg::KIND_LOAD_POINT ||
     in_kind == kmc_pkg::KIND_LOAD_CENTROID)) |=> out_valid)
    else $error("load word not answered in the next cycle");

  a_run_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == kmc_pkg::KIND_RUN) |=> (busy && !out_valid))
    else $error("run word did not hold the block busy");

  a_run_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_iterations != '0) |->
    (out_label == '0 && out_x == '0 && out_y == '0))
    else $error("run result carries non-zero read fields");

  a_conv_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_converged) |-> (out_iterations != '0))
    else $error("converged flag without any pass");

endmodule

bind kmeans_2d_clustering kmc_port_checker #(
  .LABEL_W($clog2(CENTROID_DEPTH)),
  .COORD_W(COORD_WIDTH)
) u_kmc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_kind(in_kind),
  .out_valid(out_valid), .out_label(out_label), .out_x(out_x), .out_y(out_y),
  .out_iterations(out_iterations), .out_converged(out_converged)
);
